// ===== hdl/assert_macros.svh =====
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== hdl/slab_pkg.sv =====
// Types, constants and helper functions of the slab size class allocator.
`timescale 1ns / 1ps
package slab_pkg;
	localparam int unsigned PAGE_BYTES    = 4096;
	localparam int unsigned HEADER_BYTES  = 32;
	localparam int unsigned MAX_PAGES     = 16;
	localparam int unsigned NUM_CLASSES   = 5;
	localparam int unsigned MAX_OBJ_BYTES = 512;
	localparam int unsigned STACK_DEPTH   = 128;
	localparam int unsigned MEM_DEPTH     = MAX_PAGES * STACK_DEPTH;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_UNCLAIMED = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] req_size;
		logic [3:0]  free_page;
		logic [6:0]  free_slot;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  class_index;
		logic [3:0]  page_index;
		logic [6:0]  slot_index;
		logic [11:0] byte_offset;
	} rsp_t;

	// slots per page, saturated at 127
	function automatic logic [6:0] slots_per_page(input logic [2:0] c);
		int unsigned n;
		n = (PAGE_BYTES - HEADER_BYTES) >> (5 + int'(c));
		return (n > 127) ? 7'd127 : n[6:0];
	endfunction

	function automatic logic [11:0] slot_offset(input logic [2:0] c, input logic [6:0] sl);
		int unsigned t;
		t = HEADER_BYTES + (int'(sl) << (5 + int'(c)));
		return t[11:0];
	endfunction
endpackage

// ===== hdl/slab_size_class_allocator.sv =====
// Top level of the slab size class allocator.
`timescale 1ns / 1ps
// Usage:
//  req channel: req_valid/req_stall with a req_t payload (alloc or free).
//  rsp channel: rsp_valid/rsp_stall with a rsp_t payload, one per request.
//  Path: the request is registered, decoded in S_EVAL and loaded from S_PUT;
//  an alloc that pops from an existing page's stack goes through S_READ
//  first (registered read of the stack memory). The sequencer handles one
//  request at a time and stalls the next until the last one is through.
//  Page search: per-page class and free count sit in flops, so the newest
//  non-empty page of a class is found combinationally by a priority pick.
//  Fresh pages are not swept: a per-page watermark marks the stack entries
//  below it as still holding their own index, so a claim takes no fill.
//  Reset: pages_claimed clears; no clearing pass, stack memory reads are only
//  used where it was written. The block is ready right after reset.
//  Stall: the result sits in the output register until taken; a new request
//  is still accepted meanwhile but waits to load its result behind it.
module slab_size_class_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  slab_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output slab_pkg::rsp_t      rsp
);
	import slab_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_READ, S_PUT} state_t;

	state_t      state_q;
	req_t        req_q;
	rsp_t        res_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;
	logic [4:0]  pages_claimed_q;
	logic [2:0]  page_class_q [MAX_PAGES];
	logic [6:0]  page_cnt_q   [MAX_PAGES];
	logic [6:0]  page_top_q   [MAX_PAGES];   // entries below this hold their index
	logic        use_id_q;
	logic [6:0]  rd_idx_q;

	// stack memory
	logic [6:0]  stack_mem [MEM_DEPTH];
	logic [6:0]  rd_data_q;
	logic        mem_we, mem_re;
	logic [10:0] mem_addr;
	logic [6:0]  mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= stack_mem[mem_addr];
		end
	end

	// request decode
	logic        size_ok, found;
	logic [2:0]  cls;
	logic        hit;
	logic [3:0]  hit_pg;
	logic [6:0]  n_slots;
	logic [2:0]  fpc;
	logic [6:0]  fcnt;
	logic [6:0]  hcnt;
	logic        fp_claimed;
	rsp_t        eval_res;
	logic [6:0]  rd_slot;
	logic        put_fire;

	always_comb begin
		size_ok = (req_q.req_size != 16'd0) && ({16'd0, req_q.req_size} <= MAX_OBJ_BYTES);
		found = 1'b0;
		cls = '0;
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if ({16'd0, req_q.req_size} <= (32 << i)) begin
				found = 1'b1;
				cls = i[2:0];
			end
		end
		hit = 1'b0;
		hit_pg = '0;
		for (int p = 0; p < MAX_PAGES; p++) begin
			if ((p < int'(pages_claimed_q)) && page_class_q[p] == cls && page_cnt_q[p] != 7'd0) begin
				hit = 1'b1;
				hit_pg = p[3:0];
			end
		end
		hcnt = page_cnt_q[hit_pg] - 7'd1;
		n_slots = slots_per_page(cls);
		fp_claimed = {1'b0, req_q.free_page} < pages_claimed_q;
		fpc = page_class_q[req_q.free_page];
		fcnt = page_cnt_q[req_q.free_page];

		// result of the decode stage; a stack pop fills in the slot later
		eval_res = '0;
		if (!size_ok || !found) begin
			eval_res.status = ST_BAD_SIZE;
		end else if (req_q.cmd == CMD_ALLOC) begin
			if (hit) begin
				eval_res.class_index = cls;
				eval_res.page_index = hit_pg;
			end else if (pages_claimed_q >= MAX_PAGES || n_slots == 7'd0) begin
				eval_res.status = ST_EXHAUSTED;
				eval_res.class_index = cls;
			end else begin
				eval_res.class_index = cls;
				eval_res.page_index = pages_claimed_q[3:0];
				eval_res.slot_index = n_slots - 7'd1;
				eval_res.byte_offset = slot_offset(cls, n_slots - 7'd1);
			end
		end else begin
			if (!fp_claimed) begin
				eval_res.status = ST_UNCLAIMED;
			end else if (fcnt >= slots_per_page(fpc)) begin
				eval_res.status = ST_OVERFLOW;
				eval_res.class_index = fpc;
			end else begin
				eval_res.class_index = fpc;
				eval_res.page_index = req_q.free_page;
				eval_res.slot_index = req_q.free_slot;
				eval_res.byte_offset = slot_offset(fpc, req_q.free_slot);
			end
		end

		rd_slot = use_id_q ? rd_idx_q : rd_data_q;
		put_fire = (state_q == S_PUT) && (!rsp_valid_q || !rsp_stall);

		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = {hit_pg, hcnt};
		mem_wdata = req_q.free_slot;
		if (state_q == S_EVAL && size_ok && found) begin
			if (req_q.cmd == CMD_ALLOC) begin
				mem_re = hit;
			end else if (fp_claimed && fcnt < slots_per_page(fpc)) begin
				mem_we = 1'b1;
				mem_addr = {req_q.free_page, fcnt};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pages_claimed_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (put_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_q <= eval_res;
					state_q <= S_PUT;
					if (size_ok && found) begin
						if (req_q.cmd == CMD_ALLOC) begin
							if (hit) begin
								page_cnt_q[hit_pg] <= hcnt;
								use_id_q <= hcnt < page_top_q[hit_pg];
								rd_idx_q <= hcnt;
								state_q <= S_READ;
							end else if (pages_claimed_q < MAX_PAGES && n_slots != 7'd0) begin
								pages_claimed_q <= pages_claimed_q + 5'd1;
								page_class_q[pages_claimed_q[3:0]] <= cls;
								page_cnt_q[pages_claimed_q[3:0]] <= n_slots - 7'd1;
								page_top_q[pages_claimed_q[3:0]] <= n_slots - 7'd1;
							end
						end else if (fp_claimed && fcnt < slots_per_page(fpc)) begin
							page_cnt_q[req_q.free_page] <= fcnt + 7'd1;
							if (fcnt < page_top_q[req_q.free_page]) begin
								page_top_q[req_q.free_page] <= fcnt;
							end
						end
					end
				end
				S_READ: begin
					res_q <= '{status: res_q.status, class_index: res_q.class_index,
						page_index: res_q.page_index, slot_index: rd_slot,
						byte_offset: slot_offset(res_q.class_index, rd_slot)};
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (put_fire) begin
						rsp_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_NEVER(a_pool_bound, clk, arst_n, pages_claimed_q > MAX_PAGES, "page pool overrun")
	`ASSERT_CLK(a_claim_step, clk, arst_n, pages_claimed_q != $past(pages_claimed_q) |-> pages_claimed_q == $past(pages_claimed_q) + 5'd1, "claim count jumped")
	`ASSERT_NEVER(a_mem_rw, clk, arst_n, mem_we && mem_re, "stack read and write together")
endmodule
